>>> rtl/core/bfpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared constants, codes and types of the best-fit page allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 24;
    localparam int MAX_CHUNKS   = 64;
    localparam int HEAP_PAGES   = 256;

    localparam int ADDR_W     = 20;
    localparam int REQ_W      = 21;
    localparam int STATUS_W   = 3;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGES_W    = $clog2(HEAP_PAGES + 1);
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
    // request + header + page - 1, before the shift down to pages
    localparam int NEED_W     = REQ_W + 2;
    localparam int NEEDP_W    = NEED_W - PAGE_SHIFT;
    localparam int CMP_W      = (NEEDP_W > PAGES_W) ? NEEDP_W + 1 : PAGES_W + 1;
    localparam int OFFS_W     = PAGES_W + PAGE_SHIFT + 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic [PAGES_W-1:0] pages;
        logic               in_use;
    } entry_t;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } tbl_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   granted_address;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

>>> rtl/core/bfpa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_req_if
// Request channel: allocate or free, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfpa_req_if
    import bfpa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              operation;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] release_address;

    modport source (output valid, output operation, output request_bytes,
                    output release_address, input ready);
    modport sink   (input valid, input operation, input request_bytes,
                    input release_address, output ready);
endinterface

>>> rtl/core/bfpa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_rsp_if
// Response channel: granted address and status, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfpa_rsp_if
    import bfpa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   granted_address;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output granted_address, output status,
                    input ready);
    modport sink   (input valid, input granted_address, input status,
                    output ready);
endinterface

>>> rtl/core/bfpa_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_table
// Chunk table memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bfpa_table
    import bfpa_pkg::*;
(
    input  logic     clk,
    input  tbl_req_t req,
    output entry_t   rd_data
);

    entry_t mem [MAX_CHUNKS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/bfpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_ctrl
// Sequencer: walks the chunk table one entry per read/evaluate pair through
// a shared compare unit, then merges and shifts entries on a free.
// ----------------------------------------------------------------------------
module bfpa_ctrl
    import bfpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bfpa_req_if.sink    req,
    output tbl_req_t    tbl,
    input  entry_t      rd_data,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_A_RD     = 4'd1;
    localparam logic [3:0] S_A_EV     = 4'd2;
    localparam logic [3:0] S_A_END    = 4'd3;
    localparam logic [3:0] S_F_RD     = 4'd4;
    localparam logic [3:0] S_F_EV     = 4'd5;
    localparam logic [3:0] S_F_NXT_RD = 4'd6;
    localparam logic [3:0] S_F_NXT_EV = 4'd7;
    localparam logic [3:0] S_F_MERGE  = 4'd8;
    localparam logic [3:0] S_SH_RD    = 4'd9;
    localparam logic [3:0] S_SH_WR    = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    localparam logic [OFFS_W-1:0] ADDR_MAX = OFFS_W'((1 << ADDR_W) - 1);

    // control
    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [PAGES_W-1:0]  used_pages_reg, used_pages_next;
    logic [CNT_W-1:0]    used_cnt_reg, used_cnt_next;

    // working registers
    logic [NEEDP_W-1:0]  need_pages_reg, need_pages_next;
    logic [ADDR_W-1:0]   rel_addr_reg, rel_addr_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [PAGES_W-1:0]  off_reg, off_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [PAGES_W-1:0]  best_off_reg, best_off_next;
    logic [PAGES_W-1:0]  best_pages_reg, best_pages_next;
    logic [PAGES_W-1:0]  prev_pages_reg, prev_pages_next;
    logic                prev_use_reg, prev_use_next;
    logic [PAGES_W-1:0]  cur_pages_reg, cur_pages_next;
    logic                cur_use_reg, cur_use_next;
    logic [PAGES_W-1:0]  next_pages_reg, next_pages_next;
    logic                next_free_reg, next_free_next;
    logic [CNT_W-1:0]    src_reg, src_next;
    logic [CNT_W-1:0]    dst_reg, dst_next;
    logic [CNT_W-1:0]    lim_reg, lim_next;
    result_t             res_reg, res_next;

    // shared datapath terms
    logic [NEED_W-1:0]   need_sum;
    logic [CNT_W-1:0]    idx_inc;
    logic                idx_last;
    logic [CMP_W-1:0]    entry_pages_ext;
    logic [CMP_W-1:0]    need_pages_ext;
    logic [OFFS_W-1:0]   off_addr;
    logic [OFFS_W-1:0]   append_addr;
    logic [CMP_W-1:0]    append_pages;
    logic                prev_free;
    logic [CNT_W-1:0]    used_after;
    logic [PAGES_W-1:0]  merged_pages;
    logic [IDX_W-1:0]    dest_idx;
    logic [1:0]          removed;
    logic [CNT_W-1:0]    src_first;
    logic [CNT_W-1:0]    src_inc;

    assign need_sum = NEED_W'(req.request_bytes)
                    + NEED_W'(HEADER_BYTES + PAGE_BYTES - 1);
    assign idx_inc  = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_last = (idx_inc == count_reg);

    assign entry_pages_ext = CMP_W'(rd_data.pages);
    assign need_pages_ext  = CMP_W'(need_pages_reg);
    assign off_addr    = (OFFS_W'(off_reg) << PAGE_SHIFT) + OFFS_W'(HEADER_BYTES);
    assign append_addr = (OFFS_W'(used_pages_reg) << PAGE_SHIFT)
                       + OFFS_W'(HEADER_BYTES);
    assign append_pages = CMP_W'(used_pages_reg) + need_pages_ext;

    assign prev_free    = (idx_reg != '0) && !prev_use_reg;
    assign used_after   = used_cnt_reg - CNT_W'(cur_use_reg);
    assign merged_pages = cur_pages_reg
                        + (next_free_reg ? next_pages_reg : '0)
                        + (prev_free ? prev_pages_reg : '0);
    assign dest_idx     = prev_free ? (idx_reg - IDX_W'(1)) : idx_reg;
    assign removed      = 2'(next_free_reg) + 2'(prev_free);
    assign src_first    = idx_inc + CNT_W'(next_free_reg);
    assign src_inc      = src_reg + CNT_W'(1);

    assign req.ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        used_pages_next = used_pages_reg;
        used_cnt_next   = used_cnt_reg;
        need_pages_next = need_pages_reg;
        rel_addr_next   = rel_addr_reg;
        idx_next        = idx_reg;
        off_next        = off_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_off_next   = best_off_reg;
        best_pages_next = best_pages_reg;
        prev_pages_next = prev_pages_reg;
        prev_use_next   = prev_use_reg;
        cur_pages_next  = cur_pages_reg;
        cur_use_next    = cur_use_reg;
        next_pages_next = next_pages_reg;
        next_free_next  = next_free_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        lim_next        = lim_reg;
        res_next        = res_reg;

        tbl.rd_addr = idx_reg;
        tbl.wr_en   = 1'b0;
        tbl.wr_addr = idx_reg;
        tbl.wr_data = '{pages: best_pages_reg, in_use: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    need_pages_next = NEEDP_W'(need_sum >> PAGE_SHIFT);
                    rel_addr_next   = req.release_address;
                    idx_next        = '0;
                    off_next        = '0;
                    found_next      = 1'b0;
                    prev_use_next   = 1'b1;
                    next_free_next  = 1'b0;
                    res_next        = '{granted_address: '0, status: ST_OK};
                    if (req.operation == OP_ALLOC)
                    begin
                        if (req.request_bytes == '0)
                        begin
                            res_next.status = ST_ZERO;
                            state_next      = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_A_END;
                        end
                        else
                        begin
                            state_next = S_A_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_F_RD;
                        end
                    end
                end
            end

            S_A_RD:
            begin
                state_next = S_A_EV;
            end

            S_A_EV:
            begin
                // best fit: free, big enough, strictly smaller than current best
                if (!rd_data.in_use && (entry_pages_ext >= need_pages_ext)
                    && (!found_reg || (rd_data.pages < best_pages_reg)))
                begin
                    found_next      = 1'b1;
                    best_idx_next   = idx_reg;
                    best_off_next   = off_reg;
                    best_pages_next = rd_data.pages;
                end
                off_next = off_reg + rd_data.pages;
                idx_next = idx_inc[IDX_W-1:0];
                state_next = idx_last ? S_A_END : S_A_RD;
            end

            S_A_END:
            begin
                if (found_reg)
                begin
                    tbl.wr_en   = 1'b1;
                    tbl.wr_addr = best_idx_reg;
                    used_cnt_next = used_cnt_reg + CNT_W'(1);
                    res_next.granted_address =
                        ADDR_W'((OFFS_W'(best_off_reg) << PAGE_SHIFT)
                                + OFFS_W'(HEADER_BYTES));
                end
                else if ((count_reg >= CNT_W'(MAX_CHUNKS))
                         || (append_pages > CMP_W'(HEAP_PAGES))
                         || (append_addr > ADDR_MAX))
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    tbl.wr_en   = 1'b1;
                    tbl.wr_addr = count_reg[IDX_W-1:0];
                    tbl.wr_data = '{pages: need_pages_reg[PAGES_W-1:0], in_use: 1'b1};
                    count_next      = count_reg + CNT_W'(1);
                    used_cnt_next   = used_cnt_reg + CNT_W'(1);
                    used_pages_next = used_pages_reg + need_pages_reg[PAGES_W-1:0];
                    res_next.granted_address = append_addr[ADDR_W-1:0];
                end
                state_next = S_DONE;
            end

            S_F_RD:
            begin
                state_next = S_F_EV;
            end

            S_F_EV:
            begin
                if (off_addr == OFFS_W'(rel_addr_reg))
                begin
                    cur_pages_next = rd_data.pages;
                    cur_use_next   = rd_data.in_use;
                    state_next     = idx_last ? S_F_MERGE : S_F_NXT_RD;
                end
                else
                begin
                    prev_pages_next = rd_data.pages;
                    prev_use_next   = rd_data.in_use;
                    off_next        = off_reg + rd_data.pages;
                    idx_next        = idx_inc[IDX_W-1:0];
                    if (idx_last)
                    begin
                        res_next.status = ST_UNKNOWN;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_F_RD;
                    end
                end
            end

            S_F_NXT_RD:
            begin
                tbl.rd_addr = idx_inc[IDX_W-1:0];
                state_next  = S_F_NXT_EV;
            end

            S_F_NXT_EV:
            begin
                next_pages_next = rd_data.pages;
                next_free_next  = !rd_data.in_use;
                state_next      = S_F_MERGE;
            end

            S_F_MERGE:
            begin
                if (used_after == '0)
                begin
                    // nothing left in use: the heap empties
                    count_next      = '0;
                    used_pages_next = '0;
                    used_cnt_next   = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    tbl.wr_en   = 1'b1;
                    tbl.wr_addr = dest_idx;
                    tbl.wr_data = '{pages: merged_pages, in_use: 1'b0};
                    used_cnt_next = used_after;
                    count_next    = count_reg - CNT_W'(removed);
                    lim_next      = count_reg;
                    src_next      = src_first;
                    dst_next      = CNT_W'(dest_idx) + CNT_W'(1);
                    if ((removed == 2'd0) || (src_first >= count_reg))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SH_RD;
                    end
                end
            end

            S_SH_RD:
            begin
                tbl.rd_addr = src_reg[IDX_W-1:0];
                state_next  = S_SH_WR;
            end

            S_SH_WR:
            begin
                tbl.wr_en   = 1'b1;
                tbl.wr_addr = dst_reg[IDX_W-1:0];
                tbl.wr_data = rd_data;
                src_next    = src_inc;
                dst_next    = dst_reg + CNT_W'(1);
                state_next  = (src_inc >= lim_reg) ? S_DONE : S_SH_RD;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            used_pages_reg <= '0;
            used_cnt_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            used_pages_reg <= used_pages_next;
            used_cnt_reg   <= used_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_pages_reg <= need_pages_next;
        rel_addr_reg   <= rel_addr_next;
        idx_reg        <= idx_next;
        off_reg        <= off_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_off_reg   <= best_off_next;
        best_pages_reg <= best_pages_next;
        prev_pages_reg <= prev_pages_next;
        prev_use_reg   <= prev_use_next;
        cur_pages_reg  <= cur_pages_next;
        cur_use_reg    <= cur_use_next;
        next_pages_reg <= next_pages_next;
        next_free_reg  <= next_free_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        lim_reg        <= lim_next;
        res_reg        <= res_next;
    end

endmodule

>>> rtl/core/best_fit_page_allocator_top.sv
`timescale 1ns / 1ps
// Operation: an allocate scans every chunk in the table for the best fit, else appends a new chunk;
//   a free runs an address scan, neighbor read, merge and entry shift.
// Throughput: one request at a time; the table's single read port sets the pace,
//   each entry being read and then evaluated through the shared compare unit.
// Reset: rst_n is asynchronous, active low; it clears the chunk count, page total,
//   in-use count and the response valid flag. The table memory itself is not cleared.
// ----------------------------------------------------------------------------
// best_fit_page_allocator_top
// Best-fit page allocator with coalescing: sequencer, chunk table and response
// register.
// ----------------------------------------------------------------------------
module best_fit_page_allocator_top
    import bfpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bfpa_req_if.sink   req,
    bfpa_rsp_if.source rsp
);

    tbl_req_t tbl;
    entry_t   rd_data;
    logic     res_valid;
    logic     res_ready;
    result_t  res;

    logic     out_valid_reg;
    result_t  out_reg;

    bfpa_table u_table (
        .clk     (clk),
        .req     (tbl),
        .rd_data (rd_data)
    );

    bfpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .tbl       (tbl),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register takes a new result whenever it is empty or being drained
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.granted_address = out_reg.granted_address;
    assign rsp.status          = out_reg.status;

endmodule

>>> sim/best_fit_page_allocator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_page_allocator_top_test
// Self-checking bench for the best-fit page allocator. A directed table covers
// the status codes, the size extremes, reuse, coalescing and the heap going
// empty. Random allocate/free traffic follows; most frees name a chunk in the table.
// Every response is scored in order against a local model of the chunk table,
// with random idle cycles on both the request and the response side, none in the last random phase.
// ----------------------------------------------------------------------------
module best_fit_page_allocator_top_test;
    import bfpa_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int END_DRAIN_CYCLES = 300;

    typedef struct {
        logic                op;
        logic [REQ_W-1:0]    bytes;
        logic [ADDR_W-1:0]   addr;
        bit                  fixed;
        logic [ADDR_W-1:0]   fixed_addr;
        logic [STATUS_W-1:0] fixed_status;
    } stim_row_t;

    // Typed-in results only where obvious; the rest is scored by the model.
    stim_row_t directed_rows [0:24] = '{
        '{OP_FREE,  21'd0,       20'd24,  1'b1, 20'd0,  ST_EMPTY},
        '{OP_ALLOC, 21'd0,       20'd0,   1'b1, 20'd0,  ST_ZERO},
        '{OP_ALLOC, 21'd1048576, 20'd0,   1'b1, 20'd0,  ST_FULL},
        '{OP_ALLOC, 21'd1,       20'd0,   1'b1, 20'd24, ST_OK},
        '{OP_ALLOC, 21'd4072,    20'd0,   1'b0, 20'd0,  ST_OK},
        '{OP_ALLOC, 21'd4073,    20'd0,   1'b0, 20'd0,  ST_OK},
        '{OP_FREE,  21'd0,       20'd100, 1'b1, 20'd0,  ST_UNKNOWN},
        '{OP_FREE,  21'd0,       20'd4120, 1'b0, 20'd0, ST_OK},
        '{OP_FREE,  21'd0,       20'd4120, 1'b0, 20'd0, ST_OK},
        '{OP_ALLOC, 21'd4000,    20'd0,   1'b0, 20'd0,  ST_OK},
        '{OP_FREE,  21'd0,       20'd8216, 1'b0, 20'd0, ST_OK},
        '{OP_FREE,  21'd0,       20'd4120, 1'b0, 20'd0, ST_OK},
        '{OP_ALLOC, 21'd9000,    20'd0,   1'b0, 20'd0,  ST_OK},
        '{OP_FREE,  21'd0,       20'd24,  1'b0, 20'd0,  ST_OK},
        '{OP_FREE,  21'd0,       20'd4120, 1'b0, 20'd0, ST_OK},
        '{OP_FREE,  21'd0,       20'd24,  1'b0, 20'd0,  ST_OK},
        '{OP_ALLOC, 21'd1,       20'd0,   1'b0, 20'd0,  ST_OK},
        '{OP_ALLOC, 21'd5000,    20'd0,   1'b0, 20'd0,  ST_OK},
        '{OP_ALLOC, 21'd1,       20'd0,   1'b0, 20'd0,  ST_OK},
        '{OP_ALLOC, 21'd1,       20'd0,   1'b0, 20'd0,  ST_OK},
        '{OP_ALLOC, 21'd1,       20'd0,   1'b0, 20'd0,  ST_OK},
        '{OP_FREE,  21'd0,       20'd4120, 1'b0, 20'd0, ST_OK},
        '{OP_FREE,  21'd0,       20'd16408, 1'b0, 20'd0, ST_OK},
        '{OP_ALLOC, 21'd1,       20'd0,   1'b0, 20'd0,  ST_OK},
        '{OP_ALLOC, 21'd12288,   20'd0,   1'b0, 20'd0,  ST_OK}
    };

    logic clk;
    logic rst_n;

    bfpa_req_if req_if ();
    bfpa_rsp_if rsp_if ();

    best_fit_page_allocator_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Model of the chunk table
    logic [PAGES_W-1:0] chunk_pages [MAX_CHUNKS];
    bit                 chunk_used  [MAX_CHUNKS];
    logic [CNT_W-1:0]   n_chunks;
    logic [PAGES_W-1:0] pages_total;

    result_t pending_responses [$];

    int send_idle_pct;
    int rcv_idle_pct;
    int fail_count;
    int requests_sent;
    int responses_checked;
    int heap_empties;
    int status_hits [5];

    int random_sent;
    int phase;
    int new_phase;
    int roll;
    int alloc_pct;
    int pick;
    int req_val;
    logic [REQ_W-1:0]  rnd_bytes;
    logic [ADDR_W-1:0] rnd_addr;
    result_t row_rsp;

    initial begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic void drop_chunk(input int idx);
        int i;
        for (i = idx; i + 1 < n_chunks; i++) begin
            chunk_pages[i] = chunk_pages[i + 1];
            chunk_used[i]  = chunk_used[i + 1];
        end
        n_chunks = n_chunks - 1'b1;
    endfunction

    function automatic longint chunk_offset(input int idx);
        longint offs;
        int i;
        offs = 0;
        for (i = 0; i < idx; i++)
            offs += longint'(chunk_pages[i]) * PAGE_BYTES;
        return offs;
    endfunction

    // First in-use chunk at or after start, wrapping; -1 when none.
    function automatic int used_chunk_from(input int start);
        int i;
        int idx;
        for (i = 0; i < n_chunks; i++) begin
            idx = (start + i) % n_chunks;
            if (chunk_used[idx])
                return idx;
        end
        return -1;
    endfunction

    function automatic result_t heap_model_apply(input logic op,
                                                 input logic [REQ_W-1:0] bytes,
                                                 input logic [ADDR_W-1:0] addr);
        result_t r;
        longint need;
        longint offs;
        longint best_offs;
        longint new_pages;
        longint grant;
        int i;
        int best;
        int hit;
        bit found;
        bit any_used;
        r.granted_address = '0;
        r.status = ST_OK;
        found = 1'b0;
        best = 0;
        hit = 0;
        offs = 0;
        best_offs = 0;
        if (op == OP_ALLOC) begin
            need = longint'(bytes) + HEADER_BYTES;
            if (bytes == '0) begin
                r.status = ST_ZERO;
            end else begin
                for (i = 0; i < n_chunks; i++) begin
                    if (!chunk_used[i] && longint'(chunk_pages[i]) * PAGE_BYTES >= need &&
                        (!found || chunk_pages[i] < chunk_pages[best])) begin
                        found = 1'b1;
                        best = i;
                        best_offs = offs;
                    end
                    offs += longint'(chunk_pages[i]) * PAGE_BYTES;
                end
                if (found) begin
                    chunk_used[best] = 1'b1;
                    r.granted_address = ADDR_W'(best_offs + HEADER_BYTES);
                end else begin
                    new_pages = (need + PAGE_BYTES - 1) / PAGE_BYTES;
                    grant = longint'(pages_total) * PAGE_BYTES + HEADER_BYTES;
                    if (n_chunks >= MAX_CHUNKS ||
                        longint'(pages_total) + new_pages > HEAP_PAGES ||
                        grant > longint'({ADDR_W{1'b1}})) begin
                        r.status = ST_FULL;
                    end else begin
                        chunk_pages[n_chunks] = PAGES_W'(new_pages);
                        chunk_used[n_chunks] = 1'b1;
                        n_chunks = n_chunks + 1'b1;
                        pages_total = PAGES_W'(longint'(pages_total) + new_pages);
                        r.granted_address = ADDR_W'(grant);
                    end
                end
            end
        end else begin
            if (n_chunks == '0) begin
                r.status = ST_EMPTY;
            end else begin
                for (i = 0; i < n_chunks; i++) begin
                    if (!found && offs + HEADER_BYTES == longint'(addr)) begin
                        found = 1'b1;
                        hit = i;
                    end
                    offs += longint'(chunk_pages[i]) * PAGE_BYTES;
                end
                if (!found) begin
                    r.status = ST_UNKNOWN;
                end else begin
                    // a chunk that is already free still merges
                    chunk_used[hit] = 1'b0;
                    if (hit + 1 < n_chunks && !chunk_used[hit + 1]) begin
                        chunk_pages[hit] = chunk_pages[hit] + chunk_pages[hit + 1];
                        drop_chunk(hit + 1);
                    end
                    if (hit > 0 && !chunk_used[hit - 1]) begin
                        chunk_pages[hit - 1] = chunk_pages[hit - 1] + chunk_pages[hit];
                        drop_chunk(hit);
                    end
                    any_used = 1'b0;
                    for (i = 0; i < n_chunks; i++)
                        if (chunk_used[i])
                            any_used = 1'b1;
                    if (!any_used) begin
                        n_chunks = '0;
                        pages_total = '0;
                        heap_empties++;
                    end
                end
            end
        end
        return r;
    endfunction

    // Valid stays high across back-to-back transfers; it only drops for a gap.
    task automatic send_request(input logic op, input logic [REQ_W-1:0] bytes,
                                input logic [ADDR_W-1:0] addr, input bit fixed,
                                input result_t fixed_rsp);
        int gap;
        result_t predicted;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid           <= 1'b1;
        req_if.operation       <= op;
        req_if.request_bytes   <= bytes;
        req_if.release_address <= addr;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predicted = heap_model_apply(op, bytes, addr);
        pending_responses.push_back(fixed ? fixed_rsp : predicted);
        requests_sent++;
    endtask

    // Response scoreboard and receiver back-pressure
    always @(posedge clk) begin
        result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_responses.size() == 0) begin
                $error("unexpected response: granted_address %0d status %0d",
                       rsp_if.granted_address, rsp_if.status);
                fail_count++;
            end else begin
                want = pending_responses.pop_front();
                responses_checked++;
                if (rsp_if.granted_address !== want.granted_address) begin
                    $error("granted_address: expected %0d, actual %0d",
                           want.granted_address, rsp_if.granted_address);
                    fail_count++;
                end
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                    fail_count++;
                end
                if (rsp_if.status <= ST_EMPTY)
                    status_hits[rsp_if.status]++;
            end
        end
        rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    initial begin
        #(20_000_000);
        $display("best_fit_page_allocator_top_test: FAIL");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.operation = OP_ALLOC;
        req_if.request_bytes = '0;
        req_if.release_address = '0;
        rsp_if.ready = 1'b0;
        n_chunks = '0;
        pages_total = '0;
        fail_count = 0;
        requests_sent = 0;
        responses_checked = 0;
        heap_empties = 0;
        foreach (status_hits[i])
            status_hits[i] = 0;
        send_idle_pct = 33;
        rcv_idle_pct = 70;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            row_rsp.granted_address = directed_rows[i].fixed_addr;
            row_rsp.status = directed_rows[i].fixed_status;
            send_request(directed_rows[i].op, directed_rows[i].bytes, directed_rows[i].addr,
                         directed_rows[i].fixed, row_rsp);
        end

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            new_phase = random_sent * 3 / RANDOM_ITEMS;
            if (new_phase != phase) begin
                phase = new_phase;
                send_idle_pct = (phase == 1) ? 70 : 0;
                rcv_idle_pct  = (phase == 1) ? 33 : 0;
                // hold off until the allocator has answered everything
                req_if.valid <= 1'b0;
                while (pending_responses.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            roll = $urandom_range(99);
            alloc_pct = (n_chunks >= 40 || pages_total >= 200) ? 35 : 60;
            if (roll == 0 && n_chunks > 0) begin
                // release every live chunk in scattered order; the heap ends empty
                pick = used_chunk_from($urandom_range(0, n_chunks - 1));
                while (pick >= 0) begin
                    send_request(OP_FREE, REQ_W'($urandom_range(0, 1048576)),
                                 ADDR_W'(chunk_offset(pick) + HEADER_BYTES), 1'b0, row_rsp);
                    random_sent++;
                    pick = (n_chunks > 0) ? used_chunk_from($urandom_range(0, n_chunks - 1))
                                          : -1;
                end
            end else begin
                if (roll < alloc_pct) begin
                    roll = $urandom_range(99);
                    if (roll < 5)
                        req_val = 0;
                    else if (roll < 75)
                        req_val = $urandom_range(1, 12000);
                    else if (roll < 90)
                        req_val = $urandom_range(1, 6) * PAGE_BYTES - HEADER_BYTES
                                  + $urandom_range(0, 2) - 1;
                    else
                        req_val = $urandom_range(1, 1048576);
                    rnd_bytes = REQ_W'(req_val);
                    rnd_addr = ADDR_W'($urandom);
                    send_request(OP_ALLOC, rnd_bytes, rnd_addr, 1'b0, row_rsp);
                end else begin
                    rnd_bytes = REQ_W'($urandom_range(0, 1048576));
                    if (n_chunks > 0 && roll < 88) begin
                        pick = $urandom_range(0, n_chunks - 1);
                        rnd_addr = ADDR_W'(chunk_offset(pick) + HEADER_BYTES);
                    end else if ($urandom_range(1) == 0 || n_chunks == 0) begin
                        rnd_addr = ADDR_W'($urandom);
                    end else begin
                        // near miss on a real chunk boundary
                        pick = $urandom_range(0, n_chunks - 1);
                        rnd_addr = ADDR_W'(chunk_offset(pick) + HEADER_BYTES
                                           + $urandom_range(1, 8) - (($urandom_range(1)) * 9));
                    end
                    send_request(OP_FREE, rnd_bytes, rnd_addr, 1'b0, row_rsp);
                end
                random_sent++;
            end
        end
        req_if.valid <= 1'b0;

        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (END_DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests, %0d responses scored, heap emptied by free %0d times",
                 requests_sent, responses_checked, heap_empties);
        $display("Status mix: ok %0d, zero size %0d, full %0d, unknown %0d, empty %0d",
                 status_hits[ST_OK], status_hits[ST_ZERO], status_hits[ST_FULL],
                 status_hits[ST_UNKNOWN], status_hits[ST_EMPTY]);
        if (fail_count == 0 && pending_responses.size() == 0) begin
            $display("best_fit_page_allocator_top_test: PASS");
        end else begin
            $display("best_fit_page_allocator_top_test: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bfpa_pkg.sv
rtl/core/bfpa_req_if.sv
rtl/core/bfpa_rsp_if.sv
rtl/core/bfpa_table.sv
rtl/core/bfpa_ctrl.sv
rtl/core/best_fit_page_allocator_top.sv
sim/best_fit_page_allocator_top_test.sv
